FILE: hw/rtl/lpht_pkg.sv
package lpht_pkg;

    // Field widths of one request item and one result item.
    localparam int KEY_W    = 16;
    localparam int VAL_W    = 16;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;

    // Default number of table slots.
    localparam int DEFAULT_TABLE_SLOTS = 16;

    // Request opcodes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // One table entry as it sits in the slot memory.
    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_LOAD,
        S_PROBE
    } state_t;

endpackage

FILE: hw/rtl/lpht_mod.sv
module lpht_mod #(
    parameter int DIVISOR = lpht_pkg::DEFAULT_TABLE_SLOTS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [lpht_pkg::KEY_W-1:0]          dividend,
    output logic                                done,
    output logic [$clog2(DIVISOR)-1:0]          remainder
);
    import lpht_pkg::*;

    // The quotient comes from a multiply by the rounded-up reciprocal of the
    // divisor, scaled by 2^(KEY_W + IDX_W). This scale is exact for every
    // KEY_W-bit dividend.
    localparam int IDX_W   = $clog2(DIVISOR);
    localparam int SHIFT   = KEY_W + IDX_W;
    localparam int RECIP_W = KEY_W + 2;
    localparam int PROD_W  = KEY_W + RECIP_W;
    localparam int BACK_W  = KEY_W + IDX_W + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
    localparam logic [IDX_W:0]     DIV_C = (IDX_W + 1)'(DIVISOR);

    logic                 stage_reg, stage_next;
    logic                 done_reg, done_next;
    logic [KEY_W-1:0]     num_reg, num_next;
    logic [KEY_W-1:0]     quot_reg, quot_next;
    logic [IDX_W-1:0]     rem_reg, rem_next;
    logic [PROD_W-1:0]    prod;
    logic [BACK_W-1:0]    back;
    logic [BACK_W-1:0]    diff;

    // The quotient is registered first; then quotient times divisor is subtracted
    // from the dividend, and the difference is registered as the remainder.
    always_comb
    begin
        stage_next = start;
        done_next  = stage_reg;
        num_next   = num_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        prod       = PROD_W'(dividend) * PROD_W'(RECIP);
        back       = BACK_W'(quot_reg) * BACK_W'(DIV_C);
        diff       = BACK_W'(num_reg) - back;
        if (start)
        begin
            num_next  = dividend;
            quot_next = KEY_W'(prod >> SHIFT);
        end
        if (stage_reg)
        begin
            rem_next = diff[IDX_W-1:0];
        end
    end

    // Control state is reset; the data path needs none.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= stage_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

FILE: hw/rtl/linear_probe_hash_table_unit.sv
// Channel  | Ports                        | Handshake
// ---------+------------------------------+------------------------------------
// request  | opcode, key, value           | taken when start is high, busy low
// result   | status, found_value, slot    | done high for one cycle per item
//
// An item goes through the reciprocal multiply remainder unit for the home slot,
// a read of the home slot, then one slot memory read per further probe, with 1
// to TABLE_SLOTS slots probed in all. The next item may start in the done cycle.
// After reset a clearing pass marks every slot unused; busy is high meanwhile.
// Results cannot be stalled by the receiver.
module linear_probe_hash_table_unit #(
    parameter int TABLE_SLOTS = lpht_pkg::DEFAULT_TABLE_SLOTS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 opcode,
    input  logic [lpht_pkg::KEY_W-1:0]           key,
    input  logic signed [lpht_pkg::VAL_W-1:0]    value,
    output logic                                 done,
    output logic [lpht_pkg::STATUS_W-1:0]        status,
    output logic signed [lpht_pkg::VAL_W-1:0]    found_value,
    output logic [lpht_pkg::SLOT_W-1:0]          slot
);
    import lpht_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int EXT_W = IDX_W + SLOT_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SLOTS - 1);

    // Slot memory and its registered read data.
    entry_t             mem [TABLE_SLOTS];
    entry_t             rd_data_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wr_addr;
    entry_t             mem_wr_data;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_rd_addr;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic               op_reg, op_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [VAL_W-1:0]   val_reg, val_next;
    logic               done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VAL_W-1:0]   found_value_reg, found_value_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;

    logic               accept;
    logic               mod_done;
    logic [IDX_W-1:0]   home_idx;
    logic [IDX_W-1:0]   idx_inc;
    logic [EXT_W-1:0]   slot_ext;
    logic               hit;
    logic               last_probe;

    assign accept     = (state_reg == S_IDLE) && start;
    assign idx_inc    = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
    assign slot_ext   = EXT_W'(idx_reg);
    assign hit        = rd_data_reg.used && (rd_data_reg.key == key_reg);
    assign last_probe = (cnt_reg == IDX_LAST);

    // Home slot: key modulo the table size.
    lpht_mod #(
        .DIVISOR (TABLE_SLOTS)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .dividend  (key),
        .done      (mod_done),
        .remainder (home_idx)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (idx_reg == IDX_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (mod_done)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (!rd_data_reg.used || last_probe || (op_reg == OP_SEARCH && hit))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Outputs and data path.
    always_comb
    begin
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        val_next         = val_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        found_value_next = found_value_reg;
        slot_next        = slot_reg;
        mem_we           = 1'b0;
        mem_wr_addr      = idx_reg;
        mem_wr_data      = '{used: 1'b1, key: key_reg, value: val_reg};
        mem_re           = 1'b0;
        mem_rd_addr      = idx_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                // Sweep the table once, marking each slot unused.
                mem_we      = 1'b1;
                mem_wr_data = '{used: 1'b0, key: '0, value: '0};
                idx_next    = idx_inc;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = opcode;
                    key_next = key;
                    val_next = value;
                end
            end
            S_HASH:
            begin
                if (mod_done)
                begin
                    idx_next = home_idx;
                end
            end
            S_LOAD:
            begin
                mem_re   = 1'b1;
                cnt_next = '0;
            end
            S_PROBE:
            begin
                if (!rd_data_reg.used)
                begin
                    // An unused slot takes the insert or ends the search.
                    done_next        = 1'b1;
                    found_value_next = '0;
                    if (op_reg == OP_INSERT)
                    begin
                        mem_we      = 1'b1;
                        status_next = ST_INSERTED;
                        slot_next   = slot_ext[SLOT_W-1:0];
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                        slot_next   = '0;
                    end
                end
                else if (op_reg == OP_SEARCH && hit)
                begin
                    done_next        = 1'b1;
                    status_next      = ST_FOUND;
                    found_value_next = rd_data_reg.value;
                    slot_next        = slot_ext[SLOT_W-1:0];
                end
                else if (last_probe)
                begin
                    // Every slot has been visited.
                    done_next        = 1'b1;
                    status_next      = (op_reg == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
                    found_value_next = '0;
                    slot_next        = '0;
                end
                else
                begin
                    // Step to the next slot and fetch it for the next cycle.
                    idx_next    = idx_inc;
                    cnt_next    = cnt_reg + 1'b1;
                    mem_re      = 1'b1;
                    mem_rd_addr = idx_inc;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        key_reg         <= key_next;
        val_reg         <= val_next;
        status_reg      <= status_next;
        found_value_reg <= found_value_next;
        slot_reg        <= slot_next;
    end

    // Slot memory write port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
    end

    // Slot memory read port.
    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_rd_addr];
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign found_value = found_value_reg;
    assign slot        = slot_reg;

endmodule
